FILE: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the two-wire master byte engine: tick and
// result beat layouts, command codes, sequencer steps and register indexes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TICK_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int BITCNT_W   = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TICK_W-1:0]   LOW_TICKS_RST  = 8'd5;
    localparam logic [TICK_W-1:0]   HIGH_TICKS_RST = 8'd4;
    localparam logic [BYTE_W-1:0]   BYTE_ONES      = 8'hFF;
    localparam logic [BYTE_W-1:0]   BYTE_ZERO      = 8'h00;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE  = 4'd9;

    typedef enum logic [1:0] {
        OP_ADDR  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STEP_IDLE        = 3'd0,
        STEP_START_WAIT  = 3'd1,
        STEP_START_SETUP = 3'd2,
        STEP_START_HOLD  = 3'd3,
        STEP_BIT_LOW     = 3'd4,
        STEP_BIT_WAIT    = 3'd5,
        STEP_BIT_HIGH    = 3'd6,
        STEP_TAIL        = 3'd7
    } step_t;

    // stop sequence reuses the low step codes
    localparam step_t STEP_STOP_WAIT = STEP_START_WAIT;
    localparam step_t STEP_STOP_HOLD = STEP_START_SETUP;
    localparam step_t STEP_STOP_TAIL = STEP_START_HOLD;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS = 1'b1;

    typedef struct packed {
        logic              cmd_valid;
        logic [1:0]        operation;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
        logic              scl_in;
        logic              sda_in;
    } in_t;

    typedef struct packed {
        logic              scl_low;
        logic              sda_low;
        logic              busy_res;
        logic              done_res;
        logic              ack_received;
        logic [BYTE_W-1:0] rx_byte;
    } out_t;

    typedef struct packed {
        logic [TICK_W-1:0] low_ticks;
        logic [TICK_W-1:0] high_ticks;
    } timing_t;

endpackage

FILE: src/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Two-wire bus master that sends a start and address, writes or reads bytes
// and makes stop conditions, one bus tick per input beat.
//
// Input channel: one beat per bus tick with an optional command (taken only
// when no command is in progress) and the sampled SCL and SDA levels.
// Output channel: one beat per input beat with the line drives, busy, done,
// and on done the ACK flag and received byte.
// Configuration: write low_ticks (index 0) and high_ticks (index 1) while
// idle; a zero count acts as one tick.
// The result beat for a tick is registered in the result buffer and presented
// from its head. Throughput: one tick per cycle while in_stall is low, set by
// the sequencer update feeding a two-entry result buffer.
// Reset: sequencer idle, both lines released, low_ticks 5, high_ticks 4,
// result buffer empty.
// Stall: when the receiver stalls, results collect in the two-entry buffer;
// input stall rises only when both entries are full, and no beat is lost.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  i2cm_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output i2cm_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cm_pkg::TICK_W-1:0]        cfg_data
);

    i2cm_pkg::timing_t timing_reg;
    i2cm_pkg::out_t    result;
    i2cm_pkg::out_t    q0_reg;
    i2cm_pkg::out_t    q1_reg;
    logic [1:0]        count_reg;
    logic              push;
    logic              pop;

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = q0_reg;
    assign push      = in_valid & ~in_stall;
    assign pop       = out_valid & ~out_stall;

    i2cm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_en (push),
        .item    (in_data),
        .timing  (timing_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.low_ticks  <= i2cm_pkg::LOW_TICKS_RST;
            timing_reg.high_ticks <= i2cm_pkg::HIGH_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cm_pkg::CFG_LOW_TICKS:  timing_reg.low_ticks  <= cfg_data;
                i2cm_pkg::CFG_HIGH_TICKS: timing_reg.high_ticks <= cfg_data;
                default:                  timing_reg            <= timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // result buffer: q0 is the head beat
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            q0_reg <= (push && (count_reg == 2'd1)) ? result : q1_reg;
            if (push && (count_reg == 2'd2))
            begin
                q1_reg <= result;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                q0_reg <= result;
            end
            else
            begin
                q1_reg <= result;
            end
        end
    end

endmodule

FILE: src/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bit-level sequencer: one bus tick per enabled cycle, updates the line
// drives, bit and delay counters, and forms the result beat for that tick.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick_en,
    input  i2cm_pkg::in_t    item,
    input  i2cm_pkg::timing_t timing,
    output i2cm_pkg::out_t   result
);

    i2cm_pkg::op_t                      op_reg, op_next;
    i2cm_pkg::step_t                    step_reg, step_next;
    logic [i2cm_pkg::BITCNT_W-1:0]      bit_count_reg, bit_count_next;
    logic [i2cm_pkg::TICK_W-1:0]        wait_count_reg, wait_count_next;
    logic [i2cm_pkg::BYTE_W-1:0]        shift_reg, shift_next;
    logic                               last_reg, last_next;
    logic                               ack_reg, ack_next;
    logic                               scl_reg, scl_next;
    logic                               sda_reg, sda_next;
    logic                               done;
    logic                               delay_over;
    logic [i2cm_pkg::TICK_W-1:0]        low_min;
    logic [i2cm_pkg::TICK_W-1:0]        high_min;
    i2cm_pkg::op_t                      cmd_op;

    function automatic logic bit_sda(
        input logic [i2cm_pkg::BITCNT_W-1:0] cnt,
        input logic [i2cm_pkg::BYTE_W-1:0]   shf,
        input i2cm_pkg::op_t                 op,
        input logic                          lst
    );
        logic drive;
        if (cnt > 4'd1)
        begin
            drive = ~shf[i2cm_pkg::BYTE_W-1];
        end
        else if (op == i2cm_pkg::OP_READ)
        begin
            drive = ~lst;
        end
        else
        begin
            drive = 1'b0;
        end
        return drive;
    endfunction

    assign low_min    = (timing.low_ticks == '0) ? 8'd1 : timing.low_ticks;
    assign high_min   = (timing.high_ticks == '0) ? 8'd1 : timing.high_ticks;
    assign delay_over = (wait_count_reg <= 8'd1);
    assign cmd_op     = i2cm_pkg::op_t'(item.operation);

    always_comb
    begin
        op_next         = op_reg;
        step_next       = step_reg;
        bit_count_next  = bit_count_reg;
        wait_count_next = wait_count_reg;
        shift_next      = shift_reg;
        last_next       = last_reg;
        ack_next        = ack_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        done            = 1'b0;

        if (step_reg == i2cm_pkg::STEP_IDLE)
        begin
            if (item.cmd_valid)
            begin
                if (cmd_op == i2cm_pkg::OP_STOP)
                begin
                    ack_next   = 1'b0;
                    shift_next = i2cm_pkg::BYTE_ONES;
                    last_next  = 1'b0;
                    sda_next   = 1'b1;
                    scl_next   = 1'b0;
                    op_next    = i2cm_pkg::OP_STOP;
                    step_next  = i2cm_pkg::STEP_STOP_WAIT;
                end
                else
                begin
                    bit_count_next = i2cm_pkg::BITS_PER_BYTE;
                    ack_next       = 1'b0;
                    last_next      = (cmd_op == i2cm_pkg::OP_ADDR) ? 1'b0 : item.last;
                    shift_next     = (cmd_op == i2cm_pkg::OP_READ) ? i2cm_pkg::BYTE_ONES
                                                                   : item.tx_byte;
                    op_next        = cmd_op;
                    if (cmd_op == i2cm_pkg::OP_ADDR)
                    begin
                        scl_next  = 1'b0;
                        sda_next  = 1'b0;
                        step_next = i2cm_pkg::STEP_START_WAIT;
                    end
                    else
                    begin
                        sda_next        = bit_sda(bit_count_next, shift_next, cmd_op,
                                                  last_next);
                        wait_count_next = low_min;
                        step_next       = i2cm_pkg::STEP_BIT_LOW;
                    end
                end
            end
        end
        else if (op_reg == i2cm_pkg::OP_STOP)
        begin
            case (step_reg)
                i2cm_pkg::STEP_STOP_WAIT:
                begin
                    if (item.scl_in)
                    begin
                        wait_count_next = high_min;
                        step_next       = i2cm_pkg::STEP_STOP_HOLD;
                    end
                end
                i2cm_pkg::STEP_STOP_HOLD:
                begin
                    if (delay_over)
                    begin
                        sda_next        = 1'b0;
                        wait_count_next = low_min;
                        step_next       = i2cm_pkg::STEP_STOP_TAIL;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                i2cm_pkg::STEP_STOP_TAIL:
                begin
                    if (delay_over)
                    begin
                        done      = 1'b1;
                        op_next   = i2cm_pkg::OP_ADDR;
                        step_next = i2cm_pkg::STEP_IDLE;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                default:
                begin
                    op_next   = i2cm_pkg::OP_ADDR;
                    step_next = i2cm_pkg::STEP_IDLE;
                end
            endcase
        end
        else
        begin
            case (step_reg)
                i2cm_pkg::STEP_START_WAIT:
                begin
                    if (item.scl_in)
                    begin
                        wait_count_next = low_min;
                        step_next       = i2cm_pkg::STEP_START_SETUP;
                    end
                end
                i2cm_pkg::STEP_START_SETUP:
                begin
                    if (delay_over)
                    begin
                        sda_next        = 1'b1;
                        wait_count_next = high_min;
                        step_next       = i2cm_pkg::STEP_START_HOLD;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                i2cm_pkg::STEP_START_HOLD:
                begin
                    if (delay_over)
                    begin
                        scl_next        = 1'b1;
                        sda_next        = bit_sda(bit_count_reg, shift_reg, op_reg,
                                                  last_reg);
                        wait_count_next = low_min;
                        step_next       = i2cm_pkg::STEP_BIT_LOW;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                i2cm_pkg::STEP_BIT_LOW:
                begin
                    if (delay_over)
                    begin
                        scl_next  = 1'b0;
                        step_next = i2cm_pkg::STEP_BIT_WAIT;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                i2cm_pkg::STEP_BIT_WAIT:
                begin
                    if (item.scl_in)
                    begin
                        if (bit_count_reg > 4'd1)
                        begin
                            shift_next = {shift_reg[i2cm_pkg::BYTE_W-2:0], item.sda_in};
                        end
                        else
                        begin
                            ack_next = ~item.sda_in;
                        end
                        wait_count_next = high_min;
                        step_next       = i2cm_pkg::STEP_BIT_HIGH;
                    end
                end
                i2cm_pkg::STEP_BIT_HIGH:
                begin
                    if (delay_over)
                    begin
                        scl_next = 1'b1;
                        if (bit_count_reg > 4'd0)
                        begin
                            bit_count_next = bit_count_reg - 4'd1;
                        end
                        if (bit_count_next <= 4'd1)
                        begin
                            wait_count_next = low_min;
                            step_next       = i2cm_pkg::STEP_TAIL;
                        end
                        else
                        begin
                            sda_next        = bit_sda(bit_count_next, shift_reg, op_reg,
                                                      last_reg);
                            wait_count_next = low_min;
                            step_next       = i2cm_pkg::STEP_BIT_LOW;
                        end
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                i2cm_pkg::STEP_TAIL:
                begin
                    if (delay_over)
                    begin
                        sda_next = 1'b0;
                        if (bit_count_reg == 4'd1)
                        begin
                            sda_next        = bit_sda(bit_count_reg, shift_reg, op_reg,
                                                      last_reg);
                            wait_count_next = low_min;
                            step_next       = i2cm_pkg::STEP_BIT_LOW;
                        end
                        else if (last_reg && (op_reg != i2cm_pkg::OP_ADDR))
                        begin
                            sda_next  = 1'b1;
                            scl_next  = 1'b0;
                            op_next   = i2cm_pkg::OP_STOP;
                            step_next = i2cm_pkg::STEP_STOP_WAIT;
                        end
                        else
                        begin
                            done      = 1'b1;
                            op_next   = i2cm_pkg::OP_ADDR;
                            step_next = i2cm_pkg::STEP_IDLE;
                        end
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 8'd1;
                    end
                end
                default:
                begin
                    op_next   = i2cm_pkg::OP_ADDR;
                    step_next = i2cm_pkg::STEP_IDLE;
                end
            endcase
        end

        result.scl_low      = scl_next;
        result.sda_low      = sda_next;
        result.busy_res     = (step_next != i2cm_pkg::STEP_IDLE);
        result.done_res     = done;
        result.ack_received = done & ack_next;
        result.rx_byte      = done ? shift_next : i2cm_pkg::BYTE_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= i2cm_pkg::OP_ADDR;
            step_reg       <= i2cm_pkg::STEP_IDLE;
            bit_count_reg  <= '0;
            wait_count_reg <= '0;
            shift_reg      <= i2cm_pkg::BYTE_ONES;
            last_reg       <= 1'b0;
            ack_reg        <= 1'b0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
        end
        else if (tick_en)
        begin
            op_reg         <= op_next;
            step_reg       <= step_next;
            bit_count_reg  <= bit_count_next;
            wait_count_reg <= wait_count_next;
            shift_reg      <= shift_next;
            last_reg       <= last_next;
            ack_reg        <= ack_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

endmodule
